// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the vertex transform blocks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked at every rising clock edge outside of reset.
`define VRP_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: assertion failed");
// Checked at every rising clock edge, reset included.
`define VRP_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define VRP_ASSERT(name, clk, rst, prop)
`define VRP_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

// File: rtl/vrp_pkg.sv
// ----------------------------------------------------------------------------
// vrp_pkg
// Types, constants and tables shared by the vertex rotate/project blocks.
// ----------------------------------------------------------------------------
package vrp_pkg;

  localparam int COORD_FRAC_BITS_DEF  = 12;
  localparam int TRIG_TABLE_DEPTH_DEF = 1024;

  localparam int VTX_W      = 16;
  localparam int OUT_W      = 20;
  localparam int ANGLE_W    = 16;
  localparam int OFFSET_W   = 24;
  localparam int SCREEN_W   = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [SCREEN_W-1:0] RESET_WIDTH  = SCREEN_W'(800);
  localparam logic [SCREEN_W-1:0] RESET_HEIGHT = SCREEN_W'(600);

  // Sine and cosine in Q.15, with room for +1.0 and -1.0.
  localparam int TRIG_W       = 17;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_XW    = 32;
  localparam int CORDIC_ZW    = 25;
  localparam int CORDIC_START = 652032874;

  // Rotated x and z after rounding back to coordinate scale.
  localparam int ROT_W = 19;

  localparam int QUEUE_DEPTH = 4;

  // Divider pipeline: magnitude, round add, range check, one stage per
  // quotient bit, saturation.
  localparam int DIV_LAT = OUT_W + 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ANGLE  = 2'd0,
    REG_OFFSET = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    TRIG_LOAD,
    TRIG_RUN,
    TRIG_DONE,
    TRIG_IDLE
  } trig_state_t;

  typedef struct packed {
    logic signed [VTX_W-1:0] x;
    logic signed [VTX_W-1:0] y;
    logic signed [VTX_W-1:0] z;
  } vertex_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0]   cos_q;
    logic signed [TRIG_W-1:0]   sin_q;
    logic signed [OFFSET_W-1:0] offset;
    logic [SCREEN_W-1:0]        width;
    logic [SCREEN_W-1:0]        height;
  } view_t;

  // Arctangent of 2^-i in units of 2^-24 turn.
  function automatic logic signed [CORDIC_ZW-1:0] atan_unit(input logic [3:0] i);
    logic signed [CORDIC_ZW-1:0] a;
    case (i)
      4'd0:    a = CORDIC_ZW'(2097152);
      4'd1:    a = CORDIC_ZW'(1238021);
      4'd2:    a = CORDIC_ZW'(654136);
      4'd3:    a = CORDIC_ZW'(332050);
      4'd4:    a = CORDIC_ZW'(166669);
      4'd5:    a = CORDIC_ZW'(83416);
      4'd6:    a = CORDIC_ZW'(41718);
      4'd7:    a = CORDIC_ZW'(20860);
      4'd8:    a = CORDIC_ZW'(10430);
      4'd9:    a = CORDIC_ZW'(5215);
      4'd10:   a = CORDIC_ZW'(2608);
      4'd11:   a = CORDIC_ZW'(1304);
      4'd12:   a = CORDIC_ZW'(652);
      4'd13:   a = CORDIC_ZW'(326);
      4'd14:   a = CORDIC_ZW'(163);
      default: a = CORDIC_ZW'(81);
    endcase
    return a;
  endfunction

endpackage

// File: rtl/vrp_trig.sv
// ----------------------------------------------------------------------------
// vrp_trig
// Iterative CORDIC that turns the rotation angle into Q.15 cosine and sine.
// ----------------------------------------------------------------------------
module vrp_trig import vrp_pkg::*; #(
  parameter int TRIG_TABLE_DEPTH = TRIG_TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [ANGLE_W-1:0]       angle,
  output logic                     busy,
  output logic signed [TRIG_W-1:0] cos_q,
  output logic signed [TRIG_W-1:0] sin_q
);

  localparam int ANG_BITS = $clog2(TRIG_TABLE_DEPTH);
  localparam logic [ANGLE_W-1:0] ANG_MASK =
    ~((ANGLE_W'(1) << (ANGLE_W - ANG_BITS)) - ANGLE_W'(1));
  localparam logic signed [CORDIC_XW-1:0] ROUND = CORDIC_XW'(16384);

  trig_state_t state, state_next;
  logic [3:0]                    step;
  logic signed [CORDIC_XW-1:0]   cx, cy, dx, dy, rx, ry;
  logic signed [CORDIC_ZW-1:0]   cz;
  logic [1:0]                    quad;
  logic [ANGLE_W-1:0]            qa;
  logic signed [TRIG_W-1:0]      c_r, s_r;

  always_ff @(posedge clk) begin
    if (rst || start) begin
      state <= TRIG_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    busy       = 1'b1;
    case (state)
      TRIG_LOAD: state_next = TRIG_RUN;
      TRIG_RUN: begin
        if (step == 4'(CORDIC_STEPS - 1)) begin
          state_next = TRIG_DONE;
        end
      end
      TRIG_DONE: state_next = TRIG_IDLE;
      TRIG_IDLE: busy = 1'b0;
      default:   state_next = TRIG_LOAD;
    endcase
  end

  always_comb begin
    qa  = angle & ANG_MASK;
    dx  = cy >>> step;
    dy  = cx >>> step;
    rx  = (cx + ROUND) >>> 15;
    ry  = (cy + ROUND) >>> 15;
    c_r = rx[TRIG_W-1:0];
    s_r = ry[TRIG_W-1:0];
  end

  always_ff @(posedge clk) begin
    case (state)
      TRIG_LOAD: begin
        cx   <= CORDIC_XW'(CORDIC_START);
        cy   <= '0;
        cz   <= $signed({3'b000, qa[13:0], 8'h00});
        quad <= qa[15:14];
        step <= '0;
      end
      TRIG_RUN: begin
        if (!cz[CORDIC_ZW-1]) begin
          cx <= cx - dx;
          cy <= cy + dy;
          cz <= cz - atan_unit(step);
        end else begin
          cx <= cx + dx;
          cy <= cy - dy;
          cz <= cz + atan_unit(step);
        end
        step <= step + 4'd1;
      end
      TRIG_DONE: begin
        case (quad)
          2'd0: begin cos_q <= c_r;  sin_q <= s_r;  end
          2'd1: begin cos_q <= -s_r; sin_q <= c_r;  end
          2'd2: begin cos_q <= -c_r; sin_q <= -s_r; end
          default: begin cos_q <= s_r; sin_q <= -c_r; end
        endcase
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/vrp_front.sv
// ----------------------------------------------------------------------------
// vrp_front
// Configuration registers, angle preparation and the input item queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vrp_front import vrp_pkg::*; #(
  parameter int TRIG_TABLE_DEPTH = TRIG_TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [VTX_W-1:0]    vertex_x,
  input  logic signed [VTX_W-1:0]    vertex_y,
  input  logic signed [VTX_W-1:0]    vertex_z,
  input  logic                       pop,
  output logic                       head_valid,
  output vertex_t                    head,
  output view_t                      view
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  logic [ANGLE_W-1:0]          angle;
  logic signed [OFFSET_W-1:0]  offset;
  logic [SCREEN_W-1:0]         width, height;
  logic                        trig_start, trig_busy;
  logic signed [TRIG_W-1:0]    cos_q, sin_q;

  vertex_t                     queue_mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]            wr_ptr, rd_ptr;
  logic [CNT_W-1:0]            count;
  logic                        push;

  assign trig_start = cfg_write && (cfg_reg_t'(cfg_index) == REG_ANGLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      angle  <= '0;
      offset <= '0;
      width  <= RESET_WIDTH;
      height <= RESET_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_ANGLE:  angle  <= cfg_data[ANGLE_W-1:0];
        REG_OFFSET: offset <= $signed(cfg_data[OFFSET_W-1:0]);
        REG_WIDTH:  width  <= cfg_data[SCREEN_W-1:0];
        REG_HEIGHT: height <= cfg_data[SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  vrp_trig #(
    .TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)
  ) u_trig (
    .clk   (clk),
    .rst   (rst),
    .start (trig_start),
    .angle (angle),
    .busy  (trig_busy),
    .cos_q (cos_q),
    .sin_q (sin_q)
  );

  // Items wait while the sine and cosine are being recomputed.
  assign in_stall   = (count == CNT_W'(QUEUE_DEPTH)) || trig_busy;
  assign push       = in_valid && !in_stall;
  assign head_valid = (count != '0);
  assign head       = queue_mem[rd_ptr];

  always_comb begin
    view.cos_q  = cos_q;
    view.sin_q  = sin_q;
    view.offset = offset;
    view.width  = width;
    view.height = height;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_mem[wr_ptr] <= '{x: vertex_x, y: vertex_y, z: vertex_z};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(push) - CNT_W'(pop);
    end
  end

  `VRP_ASSERT(a_busy_holds_input, clk, rst, trig_busy |-> in_stall)
  `VRP_ASSERT(a_pop_drains, clk, rst, pop && !push |=> count == $past(count) - CNT_W'(1))
  `VRP_ASSERT(a_pop_nonempty, clk, rst, pop |-> count != '0)
  `VRP_ASSERT_ALWAYS(a_reset_stalls, clk, $past(rst) |-> in_stall)

endmodule

// File: rtl/vrp_div.sv
// ----------------------------------------------------------------------------
// vrp_div
// Pipelined signed divide by a positive divisor, rounded half away from
// zero and saturated to the output range.
// ----------------------------------------------------------------------------
module vrp_div import vrp_pkg::*; #(
  parameter int NUM_W = 50,
  parameter int DEN_W = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic signed [OUT_W-1:0] quot
);

  localparam int CW_A = NUM_W + 1;
  localparam int CW_B = DEN_W + OUT_W;
  localparam int CW   = ((CW_A > CW_B) ? CW_A : CW_B) + 1;
  localparam logic [OUT_W-1:0] HALF = OUT_W'(1) << (OUT_W - 1);

  logic [NUM_W-1:0] mag_a;
  logic [DEN_W-1:0] d_a, d_b;
  logic             neg_a, neg_b;
  logic [CW-1:0]    madd_b;

  logic [CW-1:0]    r_s   [OUT_W+1];
  logic [DEN_W-1:0] d_s   [OUT_W+1];
  logic [OUT_W-1:0] q_s   [OUT_W+1];
  logic             neg_s [OUT_W+1];
  logic             ovf_s [OUT_W+1];

  logic [CW-1:0]    sub_c [OUT_W];
  logic             ge_c  [OUT_W];
  logic [OUT_W-1:0] lim;

  always_comb begin
    for (int k = 0; k < OUT_W; k++) begin
      sub_c[k] = CW'(d_s[k]) << (OUT_W - 1 - k);
      ge_c[k]  = r_s[k] >= sub_c[k];
    end
    lim = neg_s[OUT_W] ? HALF : HALF - OUT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
      neg_a <= num[NUM_W-1];
      d_a   <= den;

      madd_b <= CW'(mag_a) + CW'(d_a >> 1);
      neg_b  <= neg_a;
      d_b    <= d_a;

      // A quotient of 2^OUT_W or more saturates whatever its low bits are.
      r_s[0]   <= madd_b;
      d_s[0]   <= d_b;
      q_s[0]   <= '0;
      neg_s[0] <= neg_b;
      ovf_s[0] <= madd_b >= (CW'(d_b) << OUT_W);

      for (int k = 0; k < OUT_W; k++) begin
        r_s[k+1]   <= ge_c[k] ? r_s[k] - sub_c[k] : r_s[k];
        q_s[k+1]   <= q_s[k] | (ge_c[k] ? (OUT_W'(1) << (OUT_W - 1 - k)) : '0);
        d_s[k+1]   <= d_s[k];
        neg_s[k+1] <= neg_s[k];
        ovf_s[k+1] <= ovf_s[k];
      end

      if (ovf_s[OUT_W] || (q_s[OUT_W] > lim)) begin
        quot <= neg_s[OUT_W] ? $signed(HALF) : $signed(HALF - OUT_W'(1));
      end else begin
        quot <= neg_s[OUT_W] ? $signed(-q_s[OUT_W]) : $signed(q_s[OUT_W]);
      end
    end
  end

endmodule

// File: rtl/vrp_back.sv
// ----------------------------------------------------------------------------
// vrp_back
// Rotation, depth offset, viewport scaling and perspective divide pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vrp_back import vrp_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    head_valid,
  input  vertex_t                 head,
  input  view_t                   view,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] screen_x,
  output logic signed [OUT_W-1:0] screen_y,
  output logic                    behind_camera
);

  localparam int SHL   = (COORD_FRAC_BITS >= 12) ? COORD_FRAC_BITS - 12 : 0;
  localparam int SHR   = (COORD_FRAC_BITS >= 12) ? 0 : 12 - COORD_FRAC_BITS;
  localparam int OFF_W = OFFSET_W + SHL;
  localparam int DW    = OFF_W + 1;
  localparam int NB    = DW + 1;
  localparam int NW    = NB + 16;
  localparam int DV_W  = DW - 1;
  localparam int P_W   = VTX_W + TRIG_W;
  localparam int SUM_W = P_W + 1;
  localparam logic signed [SUM_W-1:0] ROUND = SUM_W'(16384);

  logic                       en;
  logic                       v1, v2, v3, v4;
  logic [DIV_LAT-1:0]         vd, bd;

  logic signed [P_W-1:0]      p_xc, p_zs, p_xs, p_zc;
  logic signed [VTX_W-1:0]    vy1, vy2;
  logic signed [ROT_W-1:0]    xr2, zr2;
  logic signed [SUM_W-1:0]    sx_c, sz_c, xs_c, zs_c;

  logic signed [OFF_W-1:0]    off_al;
  logic signed [DW-1:0]       d_c;
  logic                       behind_c, behind3, behind4;
  logic signed [NB-1:0]       nx_c, ny_c, nx3, ny3;
  logic [DV_W-1:0]            dv_c, dv3, dv4;
  logic signed [SCREEN_W:0]   w_s, h_s;
  logic signed [NW-1:0]       numx4, numy4;

  // The whole pipeline moves together; the front queue absorbs the stall.
  assign en  = !(out_valid && out_stall);
  assign pop = en && head_valid;

  always_comb begin
    sx_c = SUM_W'(p_xc) - SUM_W'(p_zs) + ROUND;
    sz_c = SUM_W'(p_xs) + SUM_W'(p_zc) + ROUND;
    xs_c = sx_c >>> 15;
    zs_c = sz_c >>> 15;

    off_al   = (OFF_W'(view.offset) <<< SHL) >>> SHR;
    d_c      = DW'(zr2) + DW'(off_al);
    behind_c = d_c[DW-1] || (d_c == '0);
    // A zero numerator makes the divider return zero behind the camera.
    nx_c     = behind_c ? '0 : NB'(xr2) + NB'(d_c);
    ny_c     = behind_c ? '0 : NB'(d_c) - NB'(vy2);
    dv_c     = behind_c ? DV_W'(1) : d_c[DV_W-1:0];

    w_s = $signed({1'b0, view.width});
    h_s = $signed({1'b0, view.height});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      vd <= '0;
    end else if (en) begin
      v1 <= head_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      vd <= {vd[DIV_LAT-2:0], v4};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_xc <= P_W'(head.x) * P_W'(view.cos_q);
      p_zs <= P_W'(head.z) * P_W'(view.sin_q);
      p_xs <= P_W'(head.x) * P_W'(view.sin_q);
      p_zc <= P_W'(head.z) * P_W'(view.cos_q);
      vy1  <= head.y;

      xr2 <= xs_c[ROT_W-1:0];
      zr2 <= zs_c[ROT_W-1:0];
      vy2 <= vy1;

      nx3     <= nx_c;
      ny3     <= ny_c;
      dv3     <= dv_c;
      behind3 <= behind_c;

      numx4   <= (NW'(nx3) * NW'(w_s)) <<< 3;
      numy4   <= (NW'(ny3) * NW'(h_s)) <<< 3;
      dv4     <= dv3;
      behind4 <= behind3;

      bd <= {bd[DIV_LAT-2:0], behind4};
    end
  end

  vrp_div #(
    .NUM_W(NW),
    .DEN_W(DV_W)
  ) u_div_x (
    .clk  (clk),
    .en   (en),
    .num  (numx4),
    .den  (dv4),
    .quot (screen_x)
  );

  vrp_div #(
    .NUM_W(NW),
    .DEN_W(DV_W)
  ) u_div_y (
    .clk  (clk),
    .en   (en),
    .num  (numy4),
    .den  (dv4),
    .quot (screen_y)
  );

  assign out_valid     = vd[DIV_LAT-1];
  assign behind_camera = bd[DIV_LAT-1];

  `VRP_ASSERT(a_behind_zero, clk, rst, out_valid && behind_camera |-> screen_x == '0 && screen_y == '0)
  `VRP_ASSERT(a_hold_when_stalled, clk, rst, !en |=> $stable(vd) && $stable(v4))
  `VRP_ASSERT(a_advance, clk, rst, en && vd[DIV_LAT-2] |=> out_valid)

endmodule

// File: rtl/vertex_rotate_project.sv
// ----------------------------------------------------------------------------
// vertex_rotate_project
// Rotates a vertex about the y axis, adds a depth offset and projects it
// to screen coordinates in 1/16 pixel.
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  input    in         in_valid / in_stall     vertex_x, vertex_y, vertex_z
//  output   out        out_valid / out_stall   screen_x, screen_y, behind_camera
//  config   in         cfg_write               cfg_index, cfg_data
//
// One item per cycle is accepted while in_stall is low and delivered while
// out_stall is low; each item passes the product, rotation, numerator and
// scaling registers and then the 24-stage perspective divider. After reset
// and after each angle write the CORDIC forms the sine and cosine, and
// in_stall stays high meanwhile. A stalled output holds the whole transform
// pipeline; a four-item queue keeps accepting input until it fills.
// ----------------------------------------------------------------------------
module vertex_rotate_project import vrp_pkg::*; #(
  parameter int COORD_FRAC_BITS  = COORD_FRAC_BITS_DEF,
  parameter int TRIG_TABLE_DEPTH = TRIG_TABLE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [VTX_W-1:0] vertex_x,
  input  logic signed [VTX_W-1:0] vertex_y,
  input  logic signed [VTX_W-1:0] vertex_z,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] screen_x,
  output logic signed [OUT_W-1:0] screen_y,
  output logic                    behind_camera
);

  logic    pop;
  logic    head_valid;
  vertex_t head;
  view_t   view;

  vrp_front #(
    .TRIG_TABLE_DEPTH(TRIG_TABLE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .vertex_x   (vertex_x),
    .vertex_y   (vertex_y),
    .vertex_z   (vertex_z),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .view       (view)
  );

  vrp_back #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head          (head),
    .view          (view),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .screen_x      (screen_x),
    .screen_y      (screen_y),
    .behind_camera (behind_camera)
  );

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for vertex_rotate_project. Vertices are fed from a
// queue with random gaps; the projected coordinates are predicted in the
// bench itself and compared, in order, with each item that leaves the block.
// ----------------------------------------------------------------------------
module tb;
  import vrp_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [VTX_W-1:0] x;
    logic signed [VTX_W-1:0] y;
    logic signed [VTX_W-1:0] z;
  } vtx_item_t;

  typedef struct {
    logic signed [OUT_W-1:0] sx;
    logic signed [OUT_W-1:0] sy;
    logic                    behind;
  } pixel_t;

  logic                    clk;
  logic                    rst;
  logic                    cfg_write;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [VTX_W-1:0] vertex_x;
  logic signed [VTX_W-1:0] vertex_y;
  logic signed [VTX_W-1:0] vertex_z;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [OUT_W-1:0] screen_x;
  logic signed [OUT_W-1:0] screen_y;
  logic                    behind_camera;

  vertex_rotate_project u_top (.*);

  // Bench copy of the view registers.
  logic [ANGLE_W-1:0]         view_angle;
  logic signed [OFFSET_W-1:0] view_offset;
  logic [SCREEN_W-1:0]        view_width;
  logic [SCREEN_W-1:0]        view_height;

  vtx_item_t pending_vertices[$];
  pixel_t    expected_pixels[$];
  int        errors = 0;
  int        cycles = 0;
  bit        gaps_on = 1'b1;
  bit        hold_request = 1'b0;

  longint atan_steps[CORDIC_STEPS] = '{2097152, 1238021, 654136, 332050, 166669,
    83416, 41718, 20860, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Sine and cosine in Q.15 of a binary angle, first quadrant by CORDIC.
  function automatic void sincos_q15(input logic [15:0] a16, output longint cs,
                                     output longint sn);
    longint x, y, z, dx, dy, c, s;
    x = CORDIC_START;
    y = 0;
    z = longint'(a16[13:0]) * 256;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_steps[i];
      end else begin
        x += dx; y -= dy; z += atan_steps[i];
      end
    end
    c = (x + (64'sd1 <<< 14)) >>> 15;
    s = (y + (64'sd1 <<< 14)) >>> 15;
    case (a16[15:14])
      2'd0: begin cs = c; sn = s; end
      2'd1: begin cs = -s; sn = c; end
      2'd2: begin cs = -c; sn = -s; end
      default: begin cs = s; sn = -c; end
    endcase
  endfunction

  function automatic logic signed [OUT_W-1:0] round_div_sat(longint n, longint d);
    longint m, q;
    m = (n < 0) ? -n : n;
    q = (m + d / 2) / d;
    if (n < 0) q = -q;
    if (q > 524287) q = 524287;
    if (q < -524288) q = -524288;
    return OUT_W'(q);
  endfunction

  function automatic pixel_t project_vertex(vtx_item_t v);
    pixel_t p;
    longint cs, sn, xr, zr, d;
    logic [15:0] qa;
    // Angle is quantized to the 1024-entry step size.
    qa = {view_angle[15:6], 6'd0};
    sincos_q15(qa, cs, sn);
    xr = (longint'(v.x) * cs - longint'(v.z) * sn + (64'sd1 <<< 14)) >>> 15;
    zr = (longint'(v.x) * sn + longint'(v.z) * cs + (64'sd1 <<< 14)) >>> 15;
    d = zr + longint'(view_offset);
    if (d <= 0) begin
      p.sx = '0; p.sy = '0; p.behind = 1'b1;
    end else begin
      p.sx = round_div_sat((xr + d) * longint'(view_width) * 8, d);
      p.sy = round_div_sat((d - longint'(v.y)) * longint'(view_height) * 8, d);
      p.behind = 1'b0;
    end
    return p;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (!gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // Input side.
  int send_gap = 0;
  always @(posedge clk) begin
    vtx_item_t v;
    if (rst) begin
      in_valid <= 1'b0;
      vertex_x <= '0; vertex_y <= '0; vertex_z <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        v.x = vertex_x; v.y = vertex_y; v.z = vertex_z;
        expected_pixels.push_back(project_vertex(v));
      end
      if (!(in_valid && in_stall)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_vertices.size() > 0) begin
          v = pending_vertices.pop_front();
          vertex_x <= v.x; vertex_y <= v.y; vertex_z <= v.z;
          in_valid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output side, with one long hold when requested.
  int stall_left = 0;
  always @(posedge clk) begin
    pixel_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          errors++;
          $display("%0t: unexpected item sx=%0d sy=%0d behind=%0d", $time,
                   screen_x, screen_y, behind_camera);
        end else begin
          e = expected_pixels.pop_front();
          if (screen_x !== e.sx || screen_y !== e.sy || behind_camera !== e.behind) begin
            errors++;
            $display("%0t: mismatch expected sx=%0d sy=%0d behind=%0d, got sx=%0d sy=%0d behind=%0d",
                     $time, e.sx, e.sy, e.behind, screen_x, screen_y, behind_camera);
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_ANGLE:  view_angle  = data[ANGLE_W-1:0];
      REG_OFFSET: view_offset = data;
      REG_WIDTH:  view_width  = data[SCREEN_W-1:0];
      default:    view_height = data[SCREEN_W-1:0];
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_view(input logic [15:0] a, input logic [23:0] off,
                          input logic [11:0] w, input logic [11:0] h);
    write_reg(REG_ANGLE, 24'(a));
    write_reg(REG_OFFSET, off);
    write_reg(REG_WIDTH, 24'(w));
    write_reg(REG_HEIGHT, 24'(h));
  endtask

  // Checked at the falling edge, once the rising-edge updates have settled.
  task automatic wait_idle();
    do
      @(negedge clk);
    while (pending_vertices.size() > 0 || in_valid || expected_pixels.size() > 0);
  endtask

  task automatic add_vertex(input int x, input int y, input int z);
    vtx_item_t v;
    v.x = VTX_W'(x); v.y = VTX_W'(y); v.z = VTX_W'(z);
    pending_vertices.push_back(v);
  endtask

  function automatic logic [23:0] random_offset();
    int r;
    r = $urandom_range(99);
    if (r < 70) return 24'(4096 * $urandom_range(40, 1) + $urandom_range(4095));
    if (r < 80) return (r < 75) ? 24'h7FFFFF : 24'h800000;
    return 24'($urandom);
  endfunction

  function automatic logic [11:0] random_size();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 12'd0;
    if (r < 10) return 12'd1;
    if (r < 15) return 12'd4095;
    return 12'($urandom_range(4095, 1));
  endfunction

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_ANGLE;
    cfg_data = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    vertex_x = '0; vertex_y = '0; vertex_z = '0;
    view_angle = '0;
    view_offset = '0;
    view_width = RESET_WIDTH;
    view_height = RESET_HEIGHT;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Reset view: centered points, extremes, two vertices behind the camera
    // and a tiny depth that forces saturation.
    add_vertex(0, 0, 4096);
    add_vertex(32767, 32767, 32767);
    add_vertex(-32768, -32768, 32767);
    add_vertex(0, 0, 0);
    add_vertex(0, 0, -32768);
    add_vertex(32767, -32768, 1);
    add_vertex(-32768, 32767, 1);
    add_vertex(4096, -4096, 8192);
    wait_idle();

    // Quarter turn, large offset, full-size screen.
    set_view(16'h4000, 24'h7FFFFF, 12'd4095, 12'd4095);
    add_vertex(32767, 32767, -32768);
    add_vertex(-32768, -32768, 0);
    add_vertex(0, 0, 0);
    wait_idle();

    // Most negative offset puts everything behind the camera.
    set_view(16'hFFFF, 24'h800000, 12'd1, 12'd1);
    add_vertex(32767, 32767, 32767);
    add_vertex(-32768, 0, 32767);
    wait_idle();

    // Zero screen size and a half turn.
    set_view(16'h8000, 24'd8192, 12'd0, 12'd0);
    add_vertex(4096, 4096, -4096);
    add_vertex(-32768, 32767, -2000);
    add_vertex(100, -100, 100);
    wait_idle();

    set_view(16'hC123, 24'd4096, 12'd800, 12'd600);
    add_vertex(32767, 32767, 32767);
    add_vertex(-32768, -32768, -32768);
    add_vertex(1, -1, 1);
    wait_idle();

    for (int ph = 0; ph < 13; ph++) begin
      set_view((ph % 4 == 0) ? 16'($urandom_range(1) * 16'hFFFF) : 16'($urandom),
               random_offset(), random_size(), random_size());
      gaps_on = (ph % 3 != 1);
      for (int i = 0; i < 100; i++)
        add_vertex($urandom, $urandom, $urandom);
      if (ph == 3) begin
        repeat (5) @(posedge clk);
        hold_request = 1'b1;
      end
      wait_idle();
    end

    repeat (60) @(posedge clk);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: vertex_rotate_project.f
+incdir+rtl
rtl/vrp_pkg.sv
rtl/vrp_trig.sv
rtl/vrp_front.sv
rtl/vrp_div.sv
rtl/vrp_back.sv
rtl/vertex_rotate_project.sv
sim/tb.sv
